[hw/rtl/css_pkg.sv]
`default_nettype none

package css_pkg;

   localparam int VALUE_W       = 32;
   localparam int COUNT_W       = 7;
   localparam int DEPTH_DEFAULT = 64;
   localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd64;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_DUP  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_MISS = 2'd3;

   // Per-cell control, driven by the sequencer in the top level.
   typedef struct packed {
      logic clear;
      logic compare;
      logic load;
      logic shift;
   } cell_ctl_type;

   // A capacity of zero acts as one; anything above the depth acts as the depth.
   function automatic logic [COUNT_W-1:0] eff_capacity(input logic [COUNT_W-1:0] raw,
                                                       input int depth);
      logic [COUNT_W-1:0] result;
      result = raw;
      if (raw == '0) begin
         result = COUNT_W'(1);
      end else if (int'(raw) > depth) begin
         result = COUNT_W'(depth);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/css_cell.sv]
`default_nettype none

module css_cell (
   input  wire                            clock,
   input  wire                            reset,
   input  wire css_pkg::cell_ctl_type     ctl,
   input  wire [css_pkg::VALUE_W-1:0]     key,
   input  wire [css_pkg::VALUE_W-1:0]     next_value,
   input  wire                            hit_in,
   output logic [css_pkg::VALUE_W-1:0]    slot_value,
   output logic                           hit_out
);
   import css_pkg::*;

   logic [VALUE_W-1:0] slot_ff, slot_in;
   logic               match_ff, match_in;

   // An occupied slot always holds a nonzero value.
   assign match_in   = (slot_ff != '0) && (slot_ff == key);
   assign hit_out    = hit_in | match_ff;
   assign slot_value = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      if (ctl.clear) begin
         slot_in = '0;
      end else if (ctl.load) begin
         slot_in = key;
      end else if (ctl.shift && hit_out) begin
         slot_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         match_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         match_ff <= ctl.compare ? match_in : match_ff;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/compacting_set_store.sv]
// Each item passes through a compare state, in which every cell compares its slot with the
// operand, and then an execute state, in which the result is decided and the cells write.
// The result is registered as the execute state ends. The block takes no new item until it
// is back in idle and no held result is stalled, so one item is finished before the next.
// Synchronous active-high reset empties every slot, zeroes the occupancy and sets the
// capacity to 64 (or DEPTH, if smaller). A capacity write also empties the store.
`default_nettype none

module compacting_set_store #(
   parameter int DEPTH = css_pkg::DEPTH_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire [1:0]                        req_opcode,
   input  wire signed [css_pkg::VALUE_W-1:0] req_value,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [css_pkg::COUNT_W-1:0]      rsp_occupancy,
   input  wire                              csr_write_enable,
   input  wire [css_pkg::COUNT_W-1:0]       csr_write_data
);
   import css_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_EXECUTE
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [VALUE_W-1:0]   key_ff, key_in;
   logic [COUNT_W-1:0]   fill_ff, fill_in;
   logic [COUNT_W-1:0]   cap_ff, cap_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           status_ff, status_in;

   // The cell chain: values move down toward slot 0 on a remove, and the hit
   // flag ripples up so that every cell above the match knows to shift.
   logic [VALUE_W-1:0]   slot_value [DEPTH];
   logic [DEPTH:0]       hit_chain;
   cell_ctl_type         cell_ctl [DEPTH];

   logic req_accept, any_hit, has_free, key_zero;
   logic do_insert, do_remove;

   assign req_accept = req_valid && !req_stall;
   assign any_hit    = hit_chain[DEPTH];
   assign has_free   = fill_ff < cap_ff;
   assign key_zero   = (key_ff == '0);

   // The block holds one item at a time; it also waits while a result is held.
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = fill_ff;

   assign hit_chain[0] = 1'b0;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [VALUE_W-1:0] upper;
         if (gi == DEPTH - 1) begin : g_last
            assign upper = '0;
         end else begin : g_inner
            assign upper = slot_value[gi+1];
         end

         always_comb begin
            cell_ctl[gi].clear   = csr_write_enable;
            cell_ctl[gi].compare = (state_ff == S_COMPARE);
            cell_ctl[gi].load    = do_insert && (int'(fill_ff) == gi);
            cell_ctl[gi].shift   = do_remove;
         end

         css_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (cell_ctl[gi]),
            .key        (key_ff),
            .next_value (upper),
            .hit_in     (hit_chain[gi]),
            .slot_value (slot_value[gi]),
            .hit_out    (hit_chain[gi+1])
         );
      end
   endgenerate

   // Decision made in the execute cycle, once the registered matches are known.
   always_comb begin
      do_insert = 1'b0;
      do_remove = 1'b0;
      status_in = status_ff;
      fill_in   = fill_ff;
      if (state_ff == S_EXECUTE) begin
         case (op_ff)
            OP_INSERT: begin
               if (key_zero) begin
                  status_in = has_free ? ST_DONE : ST_FULL;
               end else if (any_hit) begin
                  status_in = ST_DUP;
               end else if (has_free) begin
                  do_insert = 1'b1;
                  fill_in   = fill_ff + COUNT_W'(1);
                  status_in = ST_DONE;
               end else begin
                  status_in = ST_FULL;
               end
            end
            OP_SEARCH: begin
               if (key_zero) begin
                  status_in = has_free ? ST_DONE : ST_MISS;
               end else begin
                  status_in = any_hit ? ST_DONE : ST_MISS;
               end
            end
            OP_REMOVE: begin
               if (key_zero) begin
                  status_in = has_free ? ST_DONE : ST_MISS;
               end else if (any_hit) begin
                  do_remove = 1'b1;
                  fill_in   = fill_ff - COUNT_W'(1);
                  status_in = ST_DONE;
               end else begin
                  status_in = ST_MISS;
               end
            end
            default: begin
               status_in = ST_MISS;
            end
         endcase
      end
      // A capacity write empties the store; the user must write it only while idle (not enforced).
      if (csr_write_enable) begin
         fill_in = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      cap_in       = cap_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in    = req_opcode;
               key_in   = $unsigned(req_value);
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            state_in = S_EXECUTE;
         end
         S_EXECUTE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (csr_write_enable) begin
         cap_in = eff_capacity(csr_write_data, DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
         cap_ff       <= eff_capacity(CAPACITY_RESET, DEPTH);
         status_ff    <= ST_DONE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
         cap_ff       <= cap_in;
         status_ff    <= status_in;
      end
      op_ff  <= op_in;
      key_ff <= key_in;
   end

endmodule

`default_nettype wire

[dv/compacting_set_store_tb.sv]
`default_nettype none

module compacting_set_store_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import css_pkg::*;

   // The package names only the three real operations; the fourth code is a no-op.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int STORE_DEPTH = DEPTH_DEFAULT;

   // Cycles to let pass once the last result is in before the store is touched again.
   // The result is registered as the block leaves its execute state, so this is margin.
   localparam int DRAIN_CYCLES = 5;

   // Length of the deliberate receiver hold-off that backs the block up.
   localparam int LONG_HOLD_CYCLES = 60;

   // Cycles without any accepted item, on either channel, before the run is abandoned.
   // The longest legitimate quiet stretch is the long hold-off above.
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [1:0]         status;
      logic [COUNT_W-1:0] occupancy;
   } set_reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_opcode = OP_SEARCH;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_status;
   logic [COUNT_W-1:0]  rsp_occupancy;
   logic                csr_write_enable = 1'b0;
   logic [COUNT_W-1:0]  csr_write_data = '0;

   compacting_set_store #(
      .DEPTH (STORE_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Shadow copy of the store. The slots stay packed at the bottom in insertion order,
   // exactly as the hardware keeps them, so occupancy and every status can be derived
   // from this copy alone.
   // ---------------------------------------------------------------------------------
   logic [VALUE_W-1:0] shadow_slots [STORE_DEPTH];
   int unsigned        shadow_fill;
   logic [COUNT_W-1:0] shadow_capacity;

   // Replies worked out at acceptance time, oldest first.
   set_reply_type      predicted_replies[$];

   int                 mismatch_count = 0;

   // Sender pacing: items go out in bursts separated by idle gaps.
   int                 burst_left = 0;
   bit                 sender_gaps_on = 1'b1;

   // Raised by the backpressure test; the receiver process clears it when done.
   bit                 long_hold_req = 1'b0;

   function automatic int unsigned usable_slots(input logic [COUNT_W-1:0] raw);
      if (raw == '0) begin
         return 1;
      end
      if (int'(raw) > STORE_DEPTH) begin
         return STORE_DEPTH;
      end
      return int'(raw);
   endfunction

   function automatic void empty_shadow_store();
      foreach (shadow_slots[i]) begin
         shadow_slots[i] = '0;
      end
      shadow_fill = 0;
   endfunction

   // Applies one operation to the shadow store and returns the reply it must produce.
   // Zero is the empty marker, so operations on zero only ask whether a free slot exists.
   function automatic set_reply_type apply_set_op(input logic [1:0] op,
                                                  input logic [VALUE_W-1:0] val);
      set_reply_type reply;
      int unsigned   cap;
      bit            has_free;
      int            hit;
      cap = usable_slots(shadow_capacity);
      if (shadow_fill > cap) begin
         shadow_fill = cap;
      end
      has_free = (shadow_fill < cap);
      hit = -1;
      for (int i = 0; i < int'(shadow_fill); i++) begin
         if (hit < 0 && shadow_slots[i] == val) begin
            hit = i;
         end
      end
      reply.status = ST_MISS;
      case (op)
         OP_INSERT: begin
            if (val == '0) begin
               reply.status = has_free ? ST_DONE : ST_FULL;
            end else if (hit >= 0) begin
               reply.status = ST_DUP;
            end else if (has_free) begin
               shadow_slots[shadow_fill] = val;
               shadow_fill++;
               reply.status = ST_DONE;
            end else begin
               reply.status = ST_FULL;
            end
         end
         OP_SEARCH: begin
            if (val == '0) begin
               reply.status = has_free ? ST_DONE : ST_MISS;
            end else begin
               reply.status = (hit >= 0) ? ST_DONE : ST_MISS;
            end
         end
         OP_REMOVE: begin
            if (val == '0) begin
               reply.status = has_free ? ST_DONE : ST_MISS;
            end else if (hit >= 0) begin
               // Everything above the match slides down one slot.
               for (int i = hit; i + 1 < int'(shadow_fill); i++) begin
                  shadow_slots[i] = shadow_slots[i + 1];
               end
               shadow_slots[shadow_fill - 1] = '0;
               shadow_fill--;
               reply.status = ST_DONE;
            end
         end
         default: begin
            // The unused code leaves the store alone and reports a miss.
            reply.status = ST_MISS;
         end
      endcase
      reply.occupancy = COUNT_W'(shadow_fill);
      return reply;
   endfunction

   // ---------------------------------------------------------------------------------
   // Driving. Every task starts and ends just after a falling edge; inputs change there
   // and the handshake is sampled at the rising edge, before the block's own updates.
   // ---------------------------------------------------------------------------------
   task automatic send_item(input logic [1:0] op, input logic [VALUE_W-1:0] val);
      int gap;
      if (burst_left == 0) begin
         if (sender_gaps_on) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         // Mostly short bursts, now and then a long run with no idling at all.
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= val;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      predicted_replies.push_back(apply_set_op(op, val));
      burst_left--;
      @(negedge clock);
   endtask

   // The capacity register is only written with nothing in flight. A write also
   // empties the store, so the shadow copy is cleared along with it.
   task automatic write_capacity(input logic [COUNT_W-1:0] cap);
      req_valid <= 1'b0;
      while (predicted_replies.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shadow_capacity = cap;
      empty_shadow_store();
      burst_left = 0;
   endtask

   function automatic logic [VALUE_W-1:0] nonzero_value();
      logic [VALUE_W-1:0] v;
      // Small values collide more often, which keeps duplicates and hits common.
      v = ($urandom_range(0, 2) == 0) ? VALUE_W'($urandom_range(1, 40)) : $urandom;
      if (v == '0) begin
         v = VALUE_W'(1);
      end
      return v;
   endfunction

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Runs straight after reset, with the reset capacity of 64 in force.
   task automatic test_basic_operations();
      send_item(OP_INSERT, '0);              // empty marker with room to spare
      send_item(OP_SEARCH, '0);
      send_item(OP_REMOVE, '0);
      send_item(OP_INSERT, 32'h7FFF_FFFF);   // largest positive value
      send_item(OP_INSERT, 32'h8000_0000);   // most negative value
      send_item(OP_INSERT, 32'hFFFF_FFFF);   // minus one
      send_item(OP_INSERT, 32'h0000_0001);
      send_item(OP_INSERT, 32'h0000_0001);   // duplicate
      send_item(OP_SEARCH, 32'hFFFF_FFFF);
      send_item(OP_SEARCH, 32'h0000_0005);   // not present
      send_item(OP_REMOVE, 32'h8000_0000);   // middle entry, later ones slide down
      send_item(OP_SEARCH, 32'h0000_0001);
      send_item(OP_REMOVE, 32'h8000_0000);   // already gone
      send_item(OP_UNUSED, 32'h0000_0007);
      send_item(OP_UNUSED, 32'hFFFF_FFFF);
      send_item(OP_REMOVE, 32'h7FFF_FFFF);   // first entry
      send_item(OP_REMOVE, 32'h0000_0001);   // last entry
   endtask

   // A zero capacity behaves as one slot: the store is full after a single insert,
   // and the empty-marker operations then report full or not found.
   task automatic test_zero_capacity();
      write_capacity('0);
      send_item(OP_INSERT, 32'h0000_0005);
      send_item(OP_INSERT, 32'h0000_0006);
      send_item(OP_INSERT, '0);
      send_item(OP_SEARCH, '0);
      send_item(OP_REMOVE, '0);
      send_item(OP_INSERT, 32'h0000_0005);
      send_item(OP_REMOVE, 32'h0000_0005);
      send_item(OP_SEARCH, '0);
   endtask

   // Random operations drawn mostly from a pool a little larger than the usable
   // capacity, so inserts run into duplicates and a full store, and removes and
   // searches mostly hit. A small share is unrestricted noise.
   task automatic test_random_ops(input logic [COUNT_W-1:0] cap, input int count,
                                  input int insert_pct);
      logic [VALUE_W-1:0] pool[$];
      logic [VALUE_W-1:0] val;
      logic [1:0]         op;
      int                 roll;
      write_capacity(cap);
      repeat (usable_slots(cap) + 3) pool.push_back(nonzero_value());
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            op  = 2'($urandom_range(0, 3));
            val = ($urandom_range(0, 3) == 0) ? '0 : VALUE_W'($urandom);
         end else begin
            val  = pool[$urandom_range(0, pool.size() - 1)];
            roll = $urandom_range(0, 99);
            if (roll < insert_pct) begin
               op = OP_INSERT;
            end else if (roll < insert_pct + (100 - insert_pct) / 3) begin
               op = OP_SEARCH;
            end else begin
               op = OP_REMOVE;
            end
         end
         send_item(op, val);
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // items back to back, so the block backs up and stalls its input.
   task automatic test_backpressure();
      long_hold_req  = 1'b1;
      sender_gaps_on = 1'b0;
      burst_left     = 0;
      repeat (30) begin
         send_item(($urandom_range(0, 1) == 0) ? OP_INSERT : OP_REMOVE,
                   VALUE_W'($urandom_range(1, 12)));
      end
      sender_gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------------------
   // Receiver stall pattern: segments of random length, each with its own stall
   // probability, one of them zero so that some stretches never stall.
   // ---------------------------------------------------------------------------------
   initial begin : receiver_stall
      int segment_left;
      int stall_pct;
      segment_left = 0;
      stall_pct    = 0;
      @(negedge clock);
      forever begin
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold_req = 1'b0;
         end else begin
            if (segment_left == 0) begin
               segment_left = $urandom_range(10, 60);
               case ($urandom_range(0, 3))
                  0:       stall_pct = 0;
                  1:       stall_pct = 25;
                  2:       stall_pct = 50;
                  default: stall_pct = 80;
               endcase
            end
            segment_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Reply checking: every accepted reply is matched against the oldest prediction.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : reply_check
      set_reply_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (predicted_replies.size() == 0) begin
            $error("reply with none outstanding: status %0d, occupancy %0d",
                   rsp_status, rsp_occupancy);
            mismatch_count++;
         end else begin
            want = predicted_replies.pop_front();
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $error("occupancy mismatch: expected %0d, got %0d",
                      want.occupancy, rsp_occupancy);
               mismatch_count++;
            end
         end
      end
   end

   // The watchdog restarts whenever an item moves on either channel.
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_valid === 1'b1 && req_stall === 1'b0) ||
                   (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------
   initial begin : main_sequence
      shadow_capacity = CAPACITY_RESET;
      empty_shadow_store();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_basic_operations();
      test_zero_capacity();

      // Capacity settings run from one slot to the over-range write of 127, which
      // acts as the full depth; that phase leans on inserts so the store fills up.
      test_random_ops(7'd1,   40, 45);
      test_random_ops(7'd3,   60, 45);
      test_random_ops(7'd8,   70, 45);
      test_random_ops(7'd127, 150, 80);
      test_random_ops(7'd64,  70, 40);
      test_random_ops(7'd17,  70, 45);
      test_random_ops(7'd2,   30, 45);
      test_backpressure();

      // Let every outstanding reply arrive, then watch a little longer for strays.
      req_valid <= 1'b0;
      while (predicted_replies.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES * 2) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/css_pkg.sv
hw/rtl/css_cell.sv
hw/rtl/compacting_set_store.sv
dv/compacting_set_store_tb.sv
